[rtl/core/qcct_pkg.sv]
package qcct_pkg;

    // Default point coordinate width
    localparam int COORD_BITS_DEF = 12;

    // Image width register
    localparam int             WIDTH_BITS  = 13;
    localparam logic [12:0]    WIDTH_RESET = 13'd320;

    // Depth of the item queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Corner slots
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    // Point markers carried with each item
    typedef struct packed {
        logic last;
        logic first;
    } t_flags;

    // Width of (image_width - x): signed, wide enough for either operand
    function automatic int diff_bits(input int coord_bits);
        return ((coord_bits > WIDTH_BITS) ? coord_bits : WIDTH_BITS) + 1;
    endfunction

    // Width of a signed corner score
    function automatic int score_bits(input int coord_bits);
        return diff_bits(coord_bits) + coord_bits + 1;
    endfunction

endpackage

[rtl/core/qcct_front.sv]
module qcct_front #(
    parameter int COORD_BITS = qcct_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write
    input  logic                                   i_cfg_valid,
    input  logic [qcct_pkg::WIDTH_BITS-1:0]        i_cfg_data,
    // Point stream
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,  // point_x, point_y
    input  logic [0:0]                             i_s_tuser,  // first_point
    input  logic                                   i_s_tlast,  // last_point
    // Item toward the queue: {right, left, flags, y, x}
    output logic                                   o_q_valid,
    input  logic                                   i_q_ready,
    output logic [2*COORD_BITS+2+2*qcct_pkg::score_bits(COORD_BITS)-1:0] o_q_data
);

    localparam int DIFF_BITS  = qcct_pkg::diff_bits(COORD_BITS);
    localparam int SCORE_BITS = qcct_pkg::score_bits(COORD_BITS);
    localparam int WB         = qcct_pkg::WIDTH_BITS;

    logic [WB-1:0]                r_width;
    logic                         r_valid;
    logic [COORD_BITS-1:0]        r_x;
    logic [COORD_BITS-1:0]        r_y;
    qcct_pkg::t_flags             r_flags;
    logic signed [SCORE_BITS-1:0] r_left;
    logic signed [SCORE_BITS-1:0] r_right;

    logic [COORD_BITS-1:0]        in_x;
    logic [COORD_BITS-1:0]        in_y;
    logic [2*COORD_BITS-1:0]      left_prod;
    logic signed [DIFF_BITS-1:0]  width_diff;
    logic signed [SCORE_BITS-1:0] n_left;
    logic signed [SCORE_BITS-1:0] n_right;

    assign in_x = i_s_tdata[COORD_BITS-1:0];
    assign in_y = i_s_tdata[2*COORD_BITS-1:COORD_BITS];

    // Score both diagonals of the incoming point
    assign left_prod  = in_x * in_y;
    assign n_left     = $signed({{(SCORE_BITS-2*COORD_BITS){1'b0}}, left_prod});
    assign width_diff = $signed({{(DIFF_BITS-WB){1'b0}}, r_width})
                      - $signed({{(DIFF_BITS-COORD_BITS){1'b0}}, in_x});
    assign n_right    = width_diff * $signed({1'b0, in_y});

    // Take a new item whenever the stage is empty or drains this cycle
    assign o_s_tready = !r_valid || i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= qcct_pkg::WIDTH_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_valid <= i_s_tvalid;
            end
        end
    end

    // Load payload on accept
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_x           <= in_x;
            r_y           <= in_y;
            r_flags.first <= i_s_tuser[0];
            r_flags.last  <= i_s_tlast;
            r_left        <= n_left;
            r_right       <= n_right;
        end
    end

    assign o_q_valid = r_valid;
    assign o_q_data  = {r_right, r_left, r_flags, r_y, r_x};

endmodule

[rtl/core/qcct_queue.sv]
module qcct_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qcct_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                push;
    logic                pop;

    assign o_ready = (r_count != CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("queue occupancy beyond depth");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue occupancy did not drop on pop");

endmodule

[rtl/core/qcct_back.sv]
module qcct_back #(
    parameter int COORD_BITS = qcct_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Item from the queue
    input  logic                        i_q_valid,
    output logic                        o_q_ready,
    input  logic [2*COORD_BITS+2+2*qcct_pkg::score_bits(COORD_BITS)-1:0] i_q_data,
    // Result unit
    input  logic                        i_fin_idle,
    output logic                        o_fin_start,
    output logic [COORD_BITS-1:0]       o_fin_col [4],
    output logic [COORD_BITS-1:0]       o_fin_row [4]
);

    localparam int SCORE_BITS = qcct_pkg::score_bits(COORD_BITS);

    logic [COORD_BITS-1:0]        r_col   [4];
    logic [COORD_BITS-1:0]        r_row   [4];
    logic signed [SCORE_BITS-1:0] r_score [4];
    logic [COORD_BITS-1:0]        n_col   [4];
    logic [COORD_BITS-1:0]        n_row   [4];
    logic signed [SCORE_BITS-1:0] n_score [4];

    logic [COORD_BITS-1:0]        item_x;
    logic [COORD_BITS-1:0]        item_y;
    qcct_pkg::t_flags             item_flags;
    logic signed [SCORE_BITS-1:0] item_left;
    logic signed [SCORE_BITS-1:0] item_right;
    logic                         pop;
    logic [3:0]                   take;

    assign {item_right, item_left, item_flags, item_y, item_x} = i_q_data;

    // Hold a last point until the result unit is free
    assign o_q_ready   = !item_flags.last || i_fin_idle;
    assign pop         = i_q_valid && o_q_ready;
    assign o_fin_start = pop && item_flags.last;

    // Decide which corners the point replaces
    always_comb begin
        take[qcct_pkg::CORNER_TL] = item_flags.first ||
                                    (item_left < r_score[qcct_pkg::CORNER_TL]);
        take[qcct_pkg::CORNER_BR] = item_flags.first ||
                                    (item_left > r_score[qcct_pkg::CORNER_BR]);
        take[qcct_pkg::CORNER_TR] = item_flags.first ||
                                    (item_right < r_score[qcct_pkg::CORNER_TR]);
        take[qcct_pkg::CORNER_BL] = item_flags.first ||
                                    (item_right > r_score[qcct_pkg::CORNER_BL]);
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_col[k]   = r_col[k];
            n_row[k]   = r_row[k];
            n_score[k] = r_score[k];
            if (pop && take[k]) begin
                n_col[k]   = item_x;
                n_row[k]   = item_y;
                n_score[k] = (k == int'(qcct_pkg::CORNER_TL) ||
                              k == int'(qcct_pkg::CORNER_BR)) ? item_left : item_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_col[k]   <= '0;
                r_row[k]   <= '0;
                r_score[k] <= '0;
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                r_col[k]   <= n_col[k];
                r_row[k]   <= n_row[k];
                r_score[k] <= n_score[k];
            end
        end
    end

    // Hand the corners as they stand after this item
    assign o_fin_col = n_col;
    assign o_fin_row = n_row;

    a_seed_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && item_flags.first) |=>
            (r_col[qcct_pkg::CORNER_TL] == r_col[qcct_pkg::CORNER_BR]) &&
            (r_col[qcct_pkg::CORNER_TR] == r_col[qcct_pkg::CORNER_BL]) &&
            (r_row[qcct_pkg::CORNER_TL] == r_row[qcct_pkg::CORNER_TR]) &&
            (r_score[qcct_pkg::CORNER_TR] == r_score[qcct_pkg::CORNER_BL]))
        else $error("first point did not seed all corners");

endmodule

[rtl/core/qcct_finish.sv]
module qcct_finish #(
    parameter int COORD_BITS = qcct_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [COORD_BITS-1:0]    i_col [4],
    input  logic [COORD_BITS-1:0]    i_row [4],
    output logic                     o_idle,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // top_left_x, top_left_y, top_right_x, top_right_y, bottom_right_x, bottom_right_y,
    // bottom_left_x, bottom_left_y, center_x_quarter, center_y_quarter, width_quarter
    output logic [((11*COORD_BITS+9+7)/8)*8-1:0] o_m_tdata
);

    localparam int QB       = COORD_BITS + 3;
    localparam int RB       = COORD_BITS + 3;
    localparam int CNT_BITS = $clog2(RB);
    localparam int SQ       = 2 * COORD_BITS;
    localparam int OUT_BITS = ((11*COORD_BITS+9+7)/8)*8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_ROOT,
        ST_HOLD
    } t_state;

    t_state                r_state;
    logic [COORD_BITS-1:0] r_col [4];
    logic [COORD_BITS-1:0] r_row [4];
    logic [COORD_BITS-1:0] r_dx;
    logic [COORD_BITS-1:0] r_dy;
    logic [QB-1:0]         r_cx;
    logic [QB-1:0]         r_cy;
    logic [2*RB-1:0]       r_rad;
    logic [RB+1:0]         r_rem;
    logic [RB-1:0]         r_root;
    logic [CNT_BITS-1:0]   r_cnt;

    logic [COORD_BITS-1:0] d_trtl_x;
    logic [COORD_BITS-1:0] d_brbl_x;
    logic [COORD_BITS-1:0] d_trbr_y;
    logic [COORD_BITS-1:0] d_tlbl_y;
    logic [SQ-1:0]         dx_sq;
    logic [SQ-1:0]         dy_sq;
    logic [SQ:0]           sq_sum;
    logic [RB+1:0]         rem_sh;
    logic [RB+1:0]         trial;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

    // Edge differences of the held corners
    assign d_trtl_x = abs_diff(r_col[qcct_pkg::CORNER_TR], r_col[qcct_pkg::CORNER_TL]);
    assign d_brbl_x = abs_diff(r_col[qcct_pkg::CORNER_BR], r_col[qcct_pkg::CORNER_BL]);
    assign d_trbr_y = abs_diff(r_row[qcct_pkg::CORNER_TR], r_row[qcct_pkg::CORNER_BR]);
    assign d_tlbl_y = abs_diff(r_row[qcct_pkg::CORNER_TL], r_row[qcct_pkg::CORNER_BL]);

    // Squared bottom edge
    assign dx_sq  = r_dx * r_dx;
    assign dy_sq  = r_dy * r_dy;
    assign sq_sum = {1'b0, dx_sq} + {1'b0, dy_sq};

    // One root digit per step
    assign rem_sh = {r_rem[RB-1:0], r_rad[2*RB-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_col   <= i_col;
                        r_row   <= i_row;
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_dx    <= d_brbl_x;
                    r_dy    <= abs_diff(r_row[qcct_pkg::CORNER_BR],
                                        r_row[qcct_pkg::CORNER_BL]);
                    r_cx    <= QB'(d_trtl_x) + QB'(d_brbl_x)
                             + {r_col[qcct_pkg::CORNER_TL], 2'b00};
                    r_cy    <= QB'(d_trbr_y) + QB'(d_tlbl_y)
                             + {r_row[qcct_pkg::CORNER_TL], 2'b00};
                    r_state <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    r_rad   <= {1'b0, sq_sum, 4'b0000};
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= CNT_BITS'(RB - 1);
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[RB-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[RB-2:0], 1'b0};
                    end
                    r_rad <= {r_rad[2*RB-3:0], 2'b00};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (i_m_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_idle     = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_HOLD);
    assign o_m_tdata  = OUT_BITS'({
        r_root, r_cy, r_cx,
        r_row[qcct_pkg::CORNER_BL], r_col[qcct_pkg::CORNER_BL],
        r_row[qcct_pkg::CORNER_BR], r_col[qcct_pkg::CORNER_BR],
        r_row[qcct_pkg::CORNER_TR], r_col[qcct_pkg::CORNER_TR],
        r_row[qcct_pkg::CORNER_TL], r_col[qcct_pkg::CORNER_TL]
    });

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("result unit started while busy");

    a_root_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT && r_cnt != '0) |=> (r_state == ST_ROOT))
        else $error("root iteration left early");

    a_hold_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == ST_ROOT))
        else $error("result shown without finishing the root");

endmodule

[rtl/core/quad_corner_center_tracker_core.sv]
// Result path: a last point passes the front register, the queue and the corner update,
//   then the result unit's difference, square and root steps, at one root digit per cycle.
// Throughput: one point per cycle while the queue has room; a last point waits in the queue
//   until the previous result is taken, so the result unit works on one result at a time.
// Reset: synchronous, active low; clears the corners and scores to zero and the
//   image width to 320; no clearing pass.
module quad_corner_center_tracker_core #(
    parameter int COORD_BITS = qcct_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration: image_width
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [qcct_pkg::WIDTH_BITS-1:0]        i_cfg_data,
    // Hull points
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,  // point_x, point_y
    input  logic [0:0]                             i_s_tuser,  // first_point
    input  logic                                   i_s_tlast,  // last_point
    // Corners and center
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // top_left_x, top_left_y, top_right_x, top_right_y, bottom_right_x, bottom_right_y,
    // bottom_left_x, bottom_left_y, center_x_quarter, center_y_quarter, width_quarter
    output logic [((11*COORD_BITS+9+7)/8)*8-1:0]   o_m_tdata
);

    localparam int ITEM_BITS = 2*COORD_BITS + 2 + 2*qcct_pkg::score_bits(COORD_BITS);

    logic                  fq_valid;
    logic                  fq_ready;
    logic [ITEM_BITS-1:0]  fq_data;
    logic                  qb_valid;
    logic                  qb_ready;
    logic [ITEM_BITS-1:0]  qb_data;
    logic                  fin_idle;
    logic                  fin_start;
    logic [COORD_BITS-1:0] fin_col [4];
    logic [COORD_BITS-1:0] fin_row [4];

    assign o_cfg_ready = 1'b1;

    qcct_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_q_valid   (fq_valid),
        .i_q_ready   (fq_ready),
        .o_q_data    (fq_data)
    );

    qcct_queue #(
        .WIDTH (ITEM_BITS),
        .DEPTH (qcct_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  (fq_data),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_data  (qb_data)
    );

    qcct_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (qb_valid),
        .o_q_ready   (qb_ready),
        .i_q_data    (qb_data),
        .i_fin_idle  (fin_idle),
        .o_fin_start (fin_start),
        .o_fin_col   (fin_col),
        .o_fin_row   (fin_row)
    );

    qcct_finish #(
        .COORD_BITS (COORD_BITS)
    ) u_finish (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (fin_start),
        .i_col      (fin_col),
        .i_row      (fin_row),
        .o_idle     (fin_idle),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

[verif/quad_corner_center_tracker_core_tb.sv]
module quad_corner_center_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB             = 12;
    localparam int IN_W           = ((2*CB+7)/8)*8;
    localparam int OUT_W          = ((11*CB+9+7)/8)*8;
    localparam int SETTLE_CYCLES  = 2*CB + 16;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    // One result item, fields from the top bit down
    typedef struct packed {
        logic [2:0]  pad;
        logic [14:0] width_q;
        logic [14:0] center_y_q;
        logic [14:0] center_x_q;
        logic [11:0] bl_y;
        logic [11:0] bl_x;
        logic [11:0] br_y;
        logic [11:0] br_x;
        logic [11:0] tr_y;
        logic [11:0] tr_x;
        logic [11:0] tl_y;
        logic [11:0] tl_x;
    } t_quad_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [12:0]        i_cfg_data  = '0;
    logic               i_s_tvalid  = 1'b0;
    logic               o_s_tready;
    logic [IN_W-1:0]    i_s_tdata   = '0;
    logic [0:0]         i_s_tuser   = '0;
    logic               i_s_tlast   = 1'b0;
    logic               o_m_tvalid;
    logic               i_m_tready  = 1'b0;
    logic [OUT_W-1:0]   o_m_tdata;

    // Predictor state: corners in slot order TL, TR, BR, BL
    logic [11:0]        corner_x [4] = '{default: '0};
    logic [11:0]        corner_y [4] = '{default: '0};
    longint             corner_score [4] = '{default: 0};
    logic [12:0]        width_reg = qcct_pkg::WIDTH_RESET;

    t_quad_result       expected_q [$];
    int                 fail_count   = 0;
    int                 stall_cycles = 0;
    bit                 s_idle_on    = 1'b1;
    bit                 m_idle_on    = 1'b1;
    bit                 hold_req     = 1'b0;

    quad_corner_center_tracker_core #(
        .COORD_BITS (CB)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Corner predictor
    // ------------------------------------------------------------------
    function automatic int gap(input logic [11:0] a, input logic [11:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return 32'(r);
    endfunction

    function automatic void keep_corner(input logic [1:0] k, input logic [11:0] x,
                                        input logic [11:0] y, input longint s);
        corner_x[k]     = x;
        corner_y[k]     = y;
        corner_score[k] = s;
    endfunction

    function automatic void track_point(input logic [11:0] x, input logic [11:0] y,
                                        input logic is_first, input logic is_last);
        longint          px, py, pw, left_score, right_score;
        longint unsigned dx, dy;
        int              cx, cy;
        t_quad_result    r;
        px = x;
        py = y;
        pw = width_reg;
        left_score  = px * py;
        right_score = (pw - px) * py;

        // Seed all corners, or keep strictly better candidates
        if (is_first) begin
            keep_corner(qcct_pkg::CORNER_TL, x, y, left_score);
            keep_corner(qcct_pkg::CORNER_BR, x, y, left_score);
            keep_corner(qcct_pkg::CORNER_TR, x, y, right_score);
            keep_corner(qcct_pkg::CORNER_BL, x, y, right_score);
        end else begin
            if (left_score < corner_score[qcct_pkg::CORNER_TL])
                keep_corner(qcct_pkg::CORNER_TL, x, y, left_score);
            if (left_score > corner_score[qcct_pkg::CORNER_BR])
                keep_corner(qcct_pkg::CORNER_BR, x, y, left_score);
            if (right_score < corner_score[qcct_pkg::CORNER_TR])
                keep_corner(qcct_pkg::CORNER_TR, x, y, right_score);
            if (right_score > corner_score[qcct_pkg::CORNER_BL])
                keep_corner(qcct_pkg::CORNER_BL, x, y, right_score);
        end

        if (!is_last)
            return;

        // Build the expected corners, center and bottom width
        r       = '0;
        r.tl_x  = corner_x[qcct_pkg::CORNER_TL];
        r.tl_y  = corner_y[qcct_pkg::CORNER_TL];
        r.tr_x  = corner_x[qcct_pkg::CORNER_TR];
        r.tr_y  = corner_y[qcct_pkg::CORNER_TR];
        r.br_x  = corner_x[qcct_pkg::CORNER_BR];
        r.br_y  = corner_y[qcct_pkg::CORNER_BR];
        r.bl_x  = corner_x[qcct_pkg::CORNER_BL];
        r.bl_y  = corner_y[qcct_pkg::CORNER_BL];
        cx = gap(r.tr_x, r.tl_x) + gap(r.br_x, r.bl_x) + 4 * int'(r.tl_x);
        cy = gap(r.tr_y, r.br_y) + gap(r.tl_y, r.bl_y) + 4 * int'(r.tl_y);
        dx = gap(r.br_x, r.bl_x);
        dy = gap(r.br_y, r.bl_y);
        r.center_x_q = cx[14:0];
        r.center_y_q = cy[14:0];
        r.width_q    = 15'(root_floor(16 * (dx * dx + dy * dy)));
        expected_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_quad_result got;
        t_quad_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: TL (%0d,%0d), width %0d",
                             got.tl_x, got.tl_y, got.width_q);
            end else begin
                want = expected_q.pop_front();
                check_field("top_left_x",       want.tl_x,       got.tl_x);
                check_field("top_left_y",       want.tl_y,       got.tl_y);
                check_field("top_right_x",      want.tr_x,       got.tr_x);
                check_field("top_right_y",      want.tr_y,       got.tr_y);
                check_field("bottom_right_x",   want.br_x,       got.br_x);
                check_field("bottom_right_y",   want.br_y,       got.br_y);
                check_field("bottom_left_x",    want.bl_x,       got.bl_x);
                check_field("bottom_left_y",    want.bl_y,       got.bl_y);
                check_field("center_x_quarter", want.center_x_q, got.center_x_q);
                check_field("center_y_quarter", want.center_y_q, got.center_y_q);
                check_field("width_quarter",    want.width_q,    got.width_q);
            end
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_tready <= !(m_idle_on && ($urandom_range(99) < 30));
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_point(input logic [11:0] x, input logic [11:0] y,
                              input logic is_first, input logic is_last);
        while (s_idle_on && ($urandom_range(99) < 30)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y, x};
        i_s_tuser  <= is_first;
        i_s_tlast  <= is_last;
        do @(posedge i_clk); while (!o_s_tready);
        track_point(x, y, is_first, is_last);
    endtask

    // Drop valid, let every expected item come out, then let the pipe settle
    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [12:0] w);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        width_reg = w;
    endtask

    function automatic logic [11:0] pick_coord();
        case ($urandom_range(3))
            0:       return 12'($urandom_range(15));
            1:       return 12'($urandom_range(4095, 4080));
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_blob(input int n);
        for (int k = 0; k < n; k++)
            send_point(pick_coord(), pick_coord(), k == 0, k == n - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Points with no seed after reset compare against zero scores
    task automatic test_unseeded();
        send_point(12'd5,    12'd7,    1'b0, 1'b0);
        send_point(12'd4095, 12'd0,    1'b0, 1'b1);
        send_point(12'd4095, 12'd4095, 1'b0, 1'b1);
    endtask

    // Columns past the image width give negative right-side scores
    task automatic test_beyond_width();
        send_point(12'd400,  12'd10,   1'b1, 1'b0);
        send_point(12'd0,    12'd4095, 1'b0, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0, 1'b0);
        send_point(12'd10,   12'd4095, 1'b0, 1'b1);
    endtask

    // First and last on the same point
    task automatic test_single_point();
        send_point(12'd4095, 12'd4095, 1'b1, 1'b1);
        send_point(12'd0,    12'd0,    1'b1, 1'b1);
    endtask

    // Equal scores keep the earlier point
    task automatic test_tie();
        send_point(12'd2, 12'd3, 1'b1, 1'b0);
        send_point(12'd3, 12'd2, 1'b0, 1'b0);
        send_point(12'd6, 12'd1, 1'b0, 1'b1);
    endtask

    // Width register at its extremes, zero included
    task automatic test_width_extremes();
        write_width(13'd0);
        send_point(12'd100,  12'd200,  1'b1, 1'b0);
        send_point(12'd4095, 12'd1,    1'b0, 1'b1);
        write_width(13'h1FFF);
        send_point(12'd0,    12'd4095, 1'b1, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0, 1'b0);
        send_point(12'd4095, 12'd0,    1'b0, 1'b1);
        write_width(13'd1);
        send_point(12'd1,    12'd1,    1'b1, 1'b0);
        send_point(12'd0,    12'd9,    1'b0, 1'b1);
        write_width(13'd4096);
        send_point(12'd2048, 12'd2048, 1'b1, 1'b0);
        send_point(12'd4095, 12'd3000, 1'b0, 1'b1);
    endtask

    // Receiver holds off while short blobs keep arriving
    task automatic test_backpressure();
        s_idle_on = 1'b0;
        hold_req  = 1'b1;
        repeat (12) send_blob(2);
        s_idle_on = 1'b1;
    endtask

    // Mostly well-formed blobs, some stray points with random markers
    task automatic test_random_blobs(input int n_items, input logic [12:0] w,
                                     input bit idling);
        int sent;
        int len;
        write_width(w);
        s_idle_on = idling;
        m_idle_on = idling;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_point(pick_coord(), pick_coord(), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
                sent++;
            end else begin
                len = ($urandom_range(19) == 0) ? $urandom_range(24, 9)
                                                : $urandom_range(6, 1);
                send_blob(len);
                sent += len;
            end
        end
        s_idle_on = 1'b1;
        m_idle_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unseeded();
        test_beyond_width();
        test_single_point();
        test_tie();
        test_width_extremes();
        test_backpressure();
        test_random_blobs(120, qcct_pkg::WIDTH_RESET, 1'b0);
        test_random_blobs(120, 13'($urandom_range(4096, 1)), 1'b1);
        test_random_blobs(120, 13'($urandom_range(8191)), 1'b1);
        test_random_blobs(120, 13'($urandom_range(640, 100)), 1'b1);

        wait_quiet();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
